// ===== sv/mtm_pkg.sv =====
// shared types and constants of the median / trimmed mean filter
// used by every module of the block; depends on nothing
`default_nettype none

package mtm_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_W       = 16;
  localparam int TRIM_COUNT  = 2;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] median;
    logic [OUT_W-1:0] trimmed_mean;
    logic             too_short;
    logic             overflowed;
  } out_item_t;

  // one finished set, handed from the sorter to the divider
  typedef struct packed {
    logic [OUT_W-1:0] median;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] divisor;
    logic             too_short;
    logic             overflowed;
  } job_t;

  typedef enum logic {
    F_COLLECT,
    F_FLUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_DIV
  } back_state_t;

endpackage

`default_nettype wire

// ===== sv/mtm_front.sv =====
// front part: insertion-sorted sample row, running total and set close-out
// depends on mtm_pkg
`default_nettype none

module mtm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire mtm_pkg::in_item_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output mtm_pkg::job_t         q_job
);
  import mtm_pkg::*;

  front_state_t state_r, state_nxt;

  sample_t          cells_r [MAX_SAMPLES];
  sample_t          cells_nxt [MAX_SAMPLES];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic             dropped_r, dropped_nxt;
  logic [MAX_SAMPLES-1:0] gt;
  logic             accept;
  logic             room;
  logic [IDX_W-1:0] med_idx, max_idx;
  logic [CNT_W-1:0] n_minus1;

  assign accept = start && !busy;
  assign room   = count_r < CNT_W'(MAX_SAMPLES);

  // empty cells count as larger than any sample
  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      gt[i] = (CNT_W'(i) >= count_r) || (cells_r[i] > in_data.sample);
    end
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      if (!gt[i]) begin
        cells_nxt[i] = cells_r[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
      end else begin
        cells_nxt[i] = in_data.sample;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_COLLECT: begin
        if (accept && in_data.last) state_nxt = F_FLUSH;
      end
      F_FLUSH: begin
        if (!q_full) state_nxt = F_COLLECT;
      end
      default: state_nxt = F_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    busy   = 1'b0;
    q_push = 1'b0;
    unique case (state_r)
      F_COLLECT: busy = 1'b0;
      F_FLUSH: begin
        busy   = 1'b1;
        q_push = !q_full;
      end
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    total_nxt   = total_r;
    dropped_nxt = dropped_r;
    if (accept) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
        total_nxt = total_r + SUM_W'(in_data.sample);
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (q_push) begin
      count_nxt   = '0;
      total_nxt   = '0;
      dropped_nxt = 1'b0;
    end
  end

  // a set always holds at least one sample when it is closed
  assign n_minus1 = count_r - CNT_W'(1);
  assign med_idx  = IDX_W'(n_minus1 >> 1);
  assign max_idx  = IDX_W'(n_minus1);

  always_comb begin
    q_job.median     = OUT_W'(cells_r[med_idx]);
    q_job.sum        = total_r - SUM_W'(cells_r[0]) - SUM_W'(cells_r[max_idx]);
    q_job.divisor    = count_r - CNT_W'(TRIM_COUNT);
    q_job.too_short  = count_r < CNT_W'(3);
    q_job.overflowed = dropped_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_COLLECT;
      count_r   <= '0;
      total_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      total_r   <= total_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtm_job_queue.sv =====
// two-entry queue of finished sets between sorter and divider
// depends on mtm_pkg
`default_nettype none

module mtm_job_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mtm_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output mtm_pkg::job_t      head
);
  import mtm_pkg::*;

  job_t       slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full  = fill_r == 2'd2;
  assign empty = fill_r == 2'd0;
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) fill_nxt = fill_r + 2'd1;
    if (pop && !push) fill_nxt = fill_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ===== sv/mtm_back.sv =====
// back part: bit-serial restoring divider for the trimmed mean, result register
// depends on mtm_pkg
`default_nettype none

module mtm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire mtm_pkg::job_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  output mtm_pkg::out_item_t out_data
);
  import mtm_pkg::*;

  back_state_t state_r, state_nxt;

  job_t              job_r;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W:0]    rem_shift;
  logic              ge;
  logic              load, short_done, div_done;
  logic              out_valid_r;
  out_item_t         out_data_r;

  assign rem_shift = {rem_r, quo_r[SUM_W-1]};
  assign ge        = rem_shift >= {1'b0, job_r.divisor};
  assign rem_nxt   = ge ? CNT_W'(rem_shift - {1'b0, job_r.divisor}) : CNT_W'(rem_shift);
  assign quo_nxt   = {quo_r[SUM_W-2:0], ge};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && !q_head.too_short) state_nxt = B_DIV;
      end
      B_DIV: begin
        if (step_r == '0) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    short_done = 1'b0;
    div_done   = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        q_pop      = !q_empty;
        load       = !q_empty && !q_head.too_short;
        short_done = !q_empty && q_head.too_short;
      end
      B_DIV: div_done = step_r == '0;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= short_done || div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r  <= q_head;
      quo_r  <= q_head.sum;
      rem_r  <= '0;
      step_r <= STEP_W'(SUM_W - 1);
    end else if (state_r == B_DIV) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r - STEP_W'(1);
    end
    if (short_done) begin
      out_data_r.median       <= q_head.median;
      out_data_r.trimmed_mean <= '0;
      out_data_r.too_short    <= 1'b1;
      out_data_r.overflowed   <= q_head.overflowed;
    end else if (div_done) begin
      out_data_r.median       <= job_r.median;
      out_data_r.trimmed_mean <= OUT_W'(quo_nxt);
      out_data_r.too_short    <= 1'b0;
      out_data_r.overflowed   <= job_r.overflowed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/median_trimmed_mean_filter.sv =====
// top level of the median / trimmed mean filter
// depends on mtm_pkg, mtm_front, mtm_job_queue, mtm_back
//
// usage:
//   input: drive in_data (sample, last) with start; an item is taken at a
//   rising edge where start is high and busy is low. samples of one set go in
//   one per cycle until one is marked last; the sample row keeps them sorted
//   by insertion as they arrive.
//   after the item marked last, busy stays high while the set is closed and
//   handed to the job queue, and longer if the queue is full.
//   the divider works out one quotient bit per cycle, and sets of fewer
//   than three samples skip it.
//   output: out_valid pulses for one cycle with out_data (median,
//   trimmed_mean, too_short, overflowed). there is no back pressure: the
//   receiver must take the result in that cycle.
//   the queue holds two closed sets, so short sets that arrive faster than
//   the divider finishes them see busy stretched by the divider.
//   samples beyond MAX_SAMPLES in a set are dropped and reported as
//   overflowed. reset (synchronous, rst_n low) empties the current set and
//   the queue and cancels a division in progress; no result is lost or
//   repeated otherwise.
`default_nettype none

module median_trimmed_mean_filter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire mtm_pkg::in_item_t in_data,
  output logic                   out_valid,
  output mtm_pkg::out_item_t     out_data
);
  import mtm_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, head_job;

  mtm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  mtm_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head_job)
  );

  mtm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench of median_trimmed_mean_filter: sends sample sets through the
// input port and checks each result against a predictor kept here
// depends on mtm_pkg and the filter top level
module tb;
  import mtm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = SUM_W + 16;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  median_trimmed_mean_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // predictor copy of the current set
  sample_t   set_samples[$];
  logic      set_dropped;
  out_item_t pending_results[$];

  int error_count;
  int items_sent;
  int sets_closed;
  int short_sets;
  int overflow_sets;
  int burst_left;
  bit steady;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // sort the stored samples and form the lower median and trimmed mean
  function automatic out_item_t close_set();
    sample_t     sorted[MAX_SAMPLES];
    sample_t     key;
    int          n;
    int          j;
    int unsigned total;
    out_item_t   r;
    n = set_samples.size();
    for (int i = 0; i < n; i++) sorted[i] = set_samples[i];
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    total = 0;
    for (int i = 1; i + 1 < n; i++) total += sorted[i];
    r.median       = sorted[(n - 1) / 2];
    r.too_short    = (n < 3);
    r.trimmed_mean = (n < 3) ? '0 : OUT_W'(total / (n - TRIM_COUNT));
    r.overflowed   = set_dropped;
    return r;
  endfunction

  task automatic send_item(input sample_t s, input logic is_last);
    int       gap;
    in_item_t noise;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady)
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
    end
    burst_left--;
    if (gap > 0) begin
      noise.sample = sample_t'($urandom);
      noise.last   = 1'($urandom);
      @(negedge clk);
      start   <= 1'b0;
      in_data <= noise;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= '{sample: s, last: is_last};
    do @(posedge clk); while (busy);
    // item taken at this edge
    items_sent++;
    if (set_samples.size() < MAX_SAMPLES) set_samples.push_back(s);
    else set_dropped = 1'b1;
    if (is_last) begin
      pending_results.push_back(close_set());
      sets_closed++;
      if (set_samples.size() < 3) short_sets++;
      if (set_dropped) overflow_sets++;
      set_samples.delete();
      set_dropped = 1'b0;
    end
  endtask

  function automatic sample_t pick_sample(input sample_t prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sample_t'($urandom_range(0, 15));
      3:       return sample_t'($urandom_range(16'hfff0, 16'hffff));
      4:       return prev;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // one set of random content; lengths past the store size drop samples
  task automatic send_random_set(input int len);
    sample_t v;
    v = sample_t'($urandom);
    for (int i = 0; i < len; i++) begin
      v = pick_sample(v);
      send_item(v, i == len - 1);
    end
  endtask

  task automatic test_full_store_extremes();
    // zero, then all ones until the store is full; the last item is dropped
    send_item('0, 1'b0);
    for (int i = 0; i < MAX_SAMPLES - 1; i++) send_item('1, 1'b0);
    send_item('1, 1'b1);
  endtask

  task automatic test_short_sets();
    send_item('1, 1'b1);
    send_item(16'h1234, 1'b0);
    send_item(16'h0012, 1'b1);
    send_item('1, 1'b0);
    send_item('0, 1'b0);
    send_item(16'h8000, 1'b1);
  endtask

  task automatic test_random_sets(input int item_goal);
    int first;
    int len;
    first = items_sent;
    while (items_sent - first < item_goal) begin
      steady = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 4);
        1, 2:    len = $urandom_range(1, 3);
        3:       len = MAX_SAMPLES;
        default: len = $urandom_range(1, MAX_SAMPLES);
      endcase
      send_random_set(len);
    end
    steady = 1'b0;
  endtask

  // sets of one to four samples back to back fill the job queue and stretch busy
  task automatic test_queue_pressure(input int item_goal);
    int first;
    first = items_sent;
    steady = 1'b1;
    while (items_sent - first < item_goal) send_random_set($urandom_range(1, 4));
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got %p", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.median !== want.median) begin
          $display("%0t median: expected %0d, got %0d", $time, want.median, out_data.median);
          error_count++;
        end
        if (out_data.trimmed_mean !== want.trimmed_mean) begin
          $display("%0t trimmed_mean: expected %0d, got %0d", $time,
                   want.trimmed_mean, out_data.trimmed_mean);
          error_count++;
        end
        if (out_data.too_short !== want.too_short) begin
          $display("%0t too_short: expected %0b, got %0b", $time,
                   want.too_short, out_data.too_short);
          error_count++;
        end
        if (out_data.overflowed !== want.overflowed) begin
          $display("%0t overflowed: expected %0b, got %0b", $time,
                   want.overflowed, out_data.overflowed);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("%0t no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL median_trimmed_mean_filter");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    set_dropped   = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    sets_closed   = 0;
    short_sets    = 0;
    overflow_sets = 0;
    burst_left    = 0;
    steady        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_full_store_extremes();
    test_short_sets();
    test_random_sets(1000);
    test_queue_pressure(150);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items in %0d sets (%0d short, %0d with dropped samples)",
             items_sent, sets_closed, short_sets, overflow_sets);
    $display("%0d mismatches", error_count);
    if (error_count == 0) begin
      $display("PASS median_trimmed_mean_filter");
    end else begin
      $display("FAIL median_trimmed_mean_filter");
    end
    $finish;
  end

endmodule
